[sv/tdp_pkg.sv]
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types for the trial-division primality tester: the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tdp_pkg;

	// Width of the number field on the query channel and of the echoed value.
	localparam int unsigned NumberBits = 32;
	localparam int unsigned TestedBits = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;          // capture a new number, seed divisor and square
		logic div_start;     // clear the remainder and preset the bit counter
		logic div_step;      // one restoring-division bit
		logic advance;       // move to the next odd divisor
		logic write_result;  // load the result register
		logic result_prime;  // verdict written with write_result
	} tdp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic below_two;     // number < 2
		logic below_four;    // number < 4
		logic even;          // number is even
		logic bound_passed;  // divisor squared exceeds the number
		logic div_last;      // current division bit is the last one
		logic rem_zero;      // remainder of the finished division is zero
	} tdp_status_t;

endpackage

[sv/tdp_if.sv]
// ----------------------------------------------------------------------------
// tdp_if
// Valid/ready channel interfaces for the query and the verdict.
// ----------------------------------------------------------------------------
interface tdp_query_if
	import tdp_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic [NumberBits-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

interface tdp_verdict_if
	import tdp_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic                  is_prime;
	logic [TestedBits-1:0] tested;

	modport source (output valid, output is_prime, output tested, input ready);
	modport sink   (input valid, input is_prime, input tested, output ready);
endinterface

[sv/tdp_datapath.sv]
// ----------------------------------------------------------------------------
// tdp_datapath
// Number, divisor, divisor-squared and remainder registers, a one-bit-per-
// cycle restoring remainder unit and the result register.
// ----------------------------------------------------------------------------
module tdp_datapath
	import tdp_pkg::*;
#(
	parameter int unsigned NUM_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tdp_cmd_t              cmd,
	output tdp_status_t           status,
	input  logic [NumberBits-1:0] number,
	output logic                  is_prime,
	output logic [TestedBits-1:0] tested
);

	localparam int unsigned CntBits = $clog2(NUM_WIDTH);

	logic [NUM_WIDTH-1:0] n_q;
	logic [NUM_WIDTH-1:0] d_q;
	logic [NUM_WIDTH:0]   sq_q;
	logic [NUM_WIDTH-1:0] rem_q;
	logic [CntBits-1:0]   cnt_q;
	logic                 is_prime_q;
	logic [TestedBits-1:0] tested_q;

	logic [63:0]          number_wide;
	logic [63:0]          n_wide;
	logic [NUM_WIDTH:0]   trial;
	logic [NUM_WIDTH:0]   trial_diff;
	logic [NUM_WIDTH+1:0] sq_sum;

	assign number_wide = 64'(number);
	assign n_wide      = 64'(n_q);

	// Shift in the next dividend bit and subtract the divisor when it fits.
	assign trial      = {rem_q, n_q[cnt_q]};
	assign trial_diff = trial - {1'b0, d_q};

	// (d + 2)^2 = d^2 + 4d + 4
	assign sq_sum = {1'b0, sq_q} + {d_q, 2'b00} + (NUM_WIDTH+2)'(4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= CntBits'(NUM_WIDTH - 1);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - CntBits'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q  <= number_wide[NUM_WIDTH-1:0];
			d_q  <= NUM_WIDTH'(3);
			sq_q <= (NUM_WIDTH+1)'(9);
		end else if (cmd.advance) begin
			d_q  <= d_q + NUM_WIDTH'(2);
			sq_q <= sq_sum[NUM_WIDTH:0];
		end
		if (cmd.div_start) begin
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, d_q}) begin
				rem_q <= trial_diff[NUM_WIDTH-1:0];
			end else begin
				rem_q <= trial[NUM_WIDTH-1:0];
			end
		end
		if (cmd.write_result) begin
			is_prime_q <= cmd.result_prime;
			tested_q   <= n_wide[TestedBits-1:0];
		end
	end

	assign status.below_two    = (n_q[NUM_WIDTH-1:1] == '0);
	assign status.below_four   = (n_q[NUM_WIDTH-1:2] == '0);
	assign status.even         = !n_q[0];
	assign status.bound_passed = (sq_q > {1'b0, n_q});
	assign status.div_last     = (cnt_q == '0);
	assign status.rem_zero     = (rem_q == '0);

	assign is_prime = is_prime_q;
	assign tested   = tested_q;

endmodule

[sv/tdp_controller.sv]
// ----------------------------------------------------------------------------
// tdp_controller
// Sequencer for the trial-division loop and the handshake on both channels.
// ----------------------------------------------------------------------------
module tdp_controller
	import tdp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output tdp_cmd_t    cmd,
	input  tdp_status_t status
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       prime_q;
	logic       prime_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		prime_d = prime_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.below_two) begin
					prime_d = 1'b0;
					state_d = ST_DONE;
				end else if (status.below_four) begin
					prime_d = 1'b1;
					state_d = ST_DONE;
				end else if (status.even) begin
					prime_d = 1'b0;
					state_d = ST_DONE;
				end else if (status.bound_passed) begin
					prime_d = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (status.rem_zero) begin
					prime_d = 1'b0;
					state_d = ST_DONE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.write_result = 1'b1;
					cmd.result_prime = prime_q;
					state_d          = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prime_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			prime_q <= prime_d;
			if (cmd.write_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/trial_division_primality_test.sv]
// ----------------------------------------------------------------------------
// trial_division_primality_test
// Reports whether an unsigned number is prime by trial division with odd
// divisors up to the square root, one remainder at a time.
// ----------------------------------------------------------------------------
// Usage.
// A number arrives on the query channel and is taken by a transfer when
// valid and ready are both high; ready is high only while the block is idle.
// Only the low NUM_WIDTH bits of the number are tested. One verdict leaves on
// the verdict channel for every query: is_prime, and tested, the masked number
// (its low 32 bits).
// Numbers below four, even numbers and odd numbers below nine are decided in
// the first check after the transfer. Otherwise each odd divisor d = 3,
// 5, 7, ... with d*d no greater than the number takes a bound check,
// NUM_WIDTH steps of the bit-serial remainder unit, and an evaluation.
// The remainder unit is the single shared resource of this loop.
// One number is worked on at a time; the next is taken once the verdict has
// been moved into the output register.
// Reset clears the controller and the output valid flag; the block is ready
// as soon as reset is released. When the receiver stalls, the
// verdict is held in the output register and a further query may still be
// taken and worked on; its verdict waits until the register is free.
// ----------------------------------------------------------------------------
module trial_division_primality_test
	import tdp_pkg::*;
#(
	parameter int unsigned NUM_WIDTH = 32
) (
	input logic           clk,
	input logic           arst_n,
	tdp_query_if.sink     query,
	tdp_verdict_if.source verdict
);

	tdp_cmd_t    cmd;
	tdp_status_t status;

	// Sequencing and the handshake flags live in the controller.
	tdp_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (query.valid),
		.in_ready  (query.ready),
		.out_valid (verdict.valid),
		.out_ready (verdict.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// The datapath holds the number, the divisor, its square, the remainder
	// and the verdict payload.
	tdp_datapath #(
		.NUM_WIDTH (NUM_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.number   (query.number),
		.is_prime (verdict.is_prime),
		.tested   (verdict.tested)
	);

endmodule

[sv/tdp_checker.sv]
// ----------------------------------------------------------------------------
// tdp_checker
// Port-level checks on the primality tester, bound to the top level.
// ----------------------------------------------------------------------------
module tdp_checker
	import tdp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  q_valid,
	input logic                  q_ready,
	input logic                  v_valid,
	input logic                  v_ready,
	input logic                  v_is_prime,
	input logic [TestedBits-1:0] v_tested
);

	// A held verdict does not change while the receiver stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_valid && !v_ready |=> v_valid && $stable(v_is_prime) && $stable(v_tested))
		else $error("verdict changed while stalled");

	// After a query transfer the block is busy for at least the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready |=> !q_ready)
		else $error("query taken while busy");

	// A prime is odd, apart from two.
	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		v_valid && v_is_prime |-> v_tested[0] || (v_tested == TestedBits'(2)))
		else $error("even number reported prime");

	// Zero and one are never reported prime.
	a_small: assert property (@(posedge clk) disable iff (!arst_n)
		v_valid && v_is_prime |-> v_tested[TestedBits-1:1] != '0)
		else $error("number below two reported prime");

endmodule

bind trial_division_primality_test tdp_checker u_tdp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.q_valid    (query.valid),
	.q_ready    (query.ready),
	.v_valid    (verdict.valid),
	.v_ready    (verdict.ready),
	.v_is_prime (verdict.is_prime),
	.v_tested   (verdict.tested)
);
